// ===== rtl/pm0_pkg.sv =====
package pm0_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0,
    OP_LIT = 5'd1,
    OP_RTN = 5'd2,
    OP_LOD = 5'd3,
    OP_STO = 5'd4,
    OP_CAL = 5'd5,
    OP_INC = 5'd6,
    OP_JMP = 5'd7,
    OP_JPC = 5'd8,
    OP_SIO = 5'd9,
    OP_NEG = 5'd10,
    OP_ADD = 5'd11,
    OP_SUB = 5'd12,
    OP_MUL = 5'd13,
    OP_DIV = 5'd14,
    OP_ODD = 5'd15,
    OP_MOD = 5'd16,
    OP_EQL = 5'd17,
    OP_NEQ = 5'd18,
    OP_LSS = 5'd19,
    OP_LEQ = 5'd20,
    OP_GTR = 5'd21,
    OP_GEQ = 5'd22
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DIVZ   = 3'd1,
    ST_STACK  = 3'd2,
    ST_CODE   = 3'd3,
    ST_HALTED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_WALK_RD, S_WALK_WT, S_ACCESS, S_LOD_WT,
    S_CAL_WR, S_RTN_RD, S_RTN_WT, S_DIV_WT, S_DONE
  } state_e;

  localparam logic [WordW-1:0] SioWrite = 32'd1;
  localparam logic [WordW-1:0] SioRead  = 32'd2;

  typedef struct packed {
    logic             start;
    logic             is_mod;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quotient;
    logic [WordW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/pm0_divider.sv =====
module pm0_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pm0_pkg::div_req_t req_i,
  output pm0_pkg::div_rsp_t rsp_o
);
  import pm0_pkg::*;

  logic [WordW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic             negq_q, negq_d, negr_q, negr_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] ua, ub;

  assign ua    = req_i.dividend[WordW-1] ? -req_i.dividend : req_i.dividend;
  assign ub    = req_i.divisor[WordW-1] ? -req_i.divisor : req_i.divisor;
  assign trial = {rem_q, quo_q[WordW-1]} - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    negq_d = negq_q;
    negr_d = negr_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = ua;
      dvs_d  = ub;
      negq_d = req_i.dividend[WordW-1] ^ req_i.divisor[WordW-1];
      negr_d = req_i.dividend[WordW-1];
      busy_d = 1'b1;
      cnt_d  = 6'(WordW);
    end else if (busy_q) begin
      if (!trial[WordW]) begin
        rem_d = trial[WordW-1:0];
        quo_d = {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WordW-2:0], quo_q[WordW-1]};
        quo_d = {quo_q[WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = negq_q ? -quo_q : quo_q;
  assign rsp_o.remainder = negr_q ? -rem_q : rem_q;

endmodule

// ===== rtl/pm0_stack_machine_core.sv =====
// channel  valid/stall               payload
// in       in_valid_i / in_stall_o   operation, dest_reg, level_or_src, operand_m, in_value
// out      out_valid_o / out_stall_i next_pc, base_ptr, stack_ptr, reg_value, halted, status
// After reset the stack is cleared one word a cycle, with in_stall_o high until all words are zero.
// LOD/STO/CAL walk the static links one hop at a time through S_WALK_RD and S_WALK_WT (one
// stack read port); CAL writes four frame words in S_CAL_WR; RTN reads two; DIV/MOD wait in
// S_DIV_WT on the shared shift-subtract divider. The result is held until out_stall_i is low.
module pm0_stack_machine_core #(
  parameter int unsigned STACK_DEPTH = 2048,
  parameter int unsigned CODE_DEPTH  = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  operation_i,
  input  logic [2:0]  dest_reg_i,
  input  logic [2:0]  level_or_src_i,
  input  logic signed [31:0] operand_m_i,
  input  logic signed [31:0] in_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [$clog2(CODE_DEPTH)-1:0]  next_pc_o,
  output logic [$clog2(STACK_DEPTH)-1:0] base_ptr_o,
  output logic [$clog2(STACK_DEPTH)-1:0] stack_ptr_o,
  output logic signed [31:0] reg_value_o,
  output logic        halted_o,
  output logic [2:0]  status_o
);
  import pm0_pkg::*;

  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(CODE_DEPTH);

  state_e state_q, state_d;

  logic [WordW-1:0] stack_mem [STACK_DEPTH];
  logic [WordW-1:0] rd_data_q;
  logic             mem_we;
  logic [SW-1:0]    mem_wa, mem_ra;
  logic [WordW-1:0] mem_wd;

  logic [WordW-1:0] rf_q [8];
  logic [CW-1:0]    pc_q, pc_d;
  logic [SW-1:0]    bp_q, bp_d, sp_q, sp_d;
  logic             halt_q, halt_d;
  logic [2:0]       status_q, status_d;

  logic [4:0]       op_q;
  logic [2:0]       r_q, l_q, cnt_q, cnt_d;
  logic [WordW-1:0] m_q, iv_q;
  logic signed [WordW+1:0] base_q, base_d;
  logic [WordW-1:0] aux_q, aux_d;
  logic [SW-1:0]    clr_q;

  logic             rf_we;
  logic [WordW-1:0] rf_wd;

  div_req_t dreq;
  div_rsp_t drsp;

  pm0_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  function automatic logic st_ok(input logic signed [WordW+1:0] a);
    return (a >= 0) && (a < $signed((WordW+2)'(STACK_DEPTH)));
  endfunction

  function automatic logic cd_ok(input logic signed [WordW+1:0] a);
    return (a >= 0) && (a < $signed((WordW+2)'(CODE_DEPTH)));
  endfunction

  logic signed [WordW+1:0] m_s, a_s, b_s, wd_s, addr_s;
  logic [WordW-1:0] ra, rb, rr;
  logic [CW-1:0]    npc;

  assign m_s  = (WordW+2)'($signed(m_q));
  assign ra   = rf_q[l_q];
  assign rb   = rf_q[m_q[2:0]];
  assign rr   = rf_q[r_q];
  assign a_s  = (WordW+2)'($signed(ra));
  assign b_s  = (WordW+2)'($signed(rb));
  assign wd_s = (WordW+2)'($signed(rd_data_q));
  assign npc  = (pc_q == CW'(CODE_DEPTH - 1)) ? '0 : pc_q + CW'(1);
  assign addr_s = base_q + m_s;

  always_comb begin
    state_d  = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SW'(STACK_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_DONE:  if (!out_stall_i) state_d = S_IDLE;
      default: ;
    endcase
    pc_d = pc_q; bp_d = bp_q; sp_d = sp_q; halt_d = halt_q; status_d = status_q;
    cnt_d = cnt_q; base_d = base_q; aux_d = aux_q;
    rf_we = 1'b0; rf_wd = '0;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
    dreq = '{start: 1'b0, is_mod: 1'b0, dividend: ra, divisor: rb};
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1; mem_wa = clr_q;
    end
    unique case (state_q)
      S_EXEC: begin
        state_d  = S_DONE;
        status_d = ST_OK;
        base_d   = (WordW+2)'(bp_q);
        cnt_d    = l_q;
        if (halt_q) status_d = ST_HALTED;
        else begin
          unique case (op_q)
            OP_LIT: begin rf_we = 1'b1; rf_wd = m_q; pc_d = npc; end
            OP_RTN: begin
              if (bp_q < SW'(1) || !st_ok((WordW+2)'(bp_q) + 3)) status_d = ST_STACK;
              else begin
                mem_ra = bp_q + SW'(2); state_d = S_RTN_RD;
              end
            end
            OP_LOD, OP_STO: state_d = S_WALK_RD;
            OP_CAL: begin
              if (!st_ok((WordW+2)'(sp_q) + 4)) status_d = ST_STACK;
              else state_d = S_WALK_RD;
            end
            OP_INC: begin
              if (!st_ok((WordW+2)'(sp_q) + m_s)) status_d = ST_STACK;
              else begin sp_d = SW'((WordW+2)'(sp_q) + m_s); pc_d = npc; end
            end
            OP_JMP: begin
              if (!cd_ok(m_s)) status_d = ST_CODE; else pc_d = CW'(m_q);
            end
            OP_JPC: begin
              if (rr == '0) begin
                if (!cd_ok(m_s)) status_d = ST_CODE; else pc_d = CW'(m_q);
              end else pc_d = npc;
            end
            OP_SIO: begin
              if (m_q == SioWrite) pc_d = npc;
              else if (m_q == SioRead) begin rf_we = 1'b1; rf_wd = iv_q; pc_d = npc; end
              else begin halt_d = 1'b1; pc_d = '0; sp_d = '0; end
            end
            OP_NEG: begin rf_we = 1'b1; rf_wd = -ra; pc_d = npc; end
            OP_ADD: begin rf_we = 1'b1; rf_wd = ra + rb; pc_d = npc; end
            OP_SUB: begin rf_we = 1'b1; rf_wd = ra - rb; pc_d = npc; end
            OP_MUL: begin rf_we = 1'b1; rf_wd = ra * rb; pc_d = npc; end
            OP_DIV, OP_MOD: begin
              if (rb == '0) status_d = ST_DIVZ;
              else begin
                dreq.start = 1'b1; dreq.is_mod = (op_q == OP_MOD); state_d = S_DIV_WT;
              end
            end
            OP_ODD: begin
              rf_we = 1'b1; rf_wd = {31'd0, rr[0]};
              if (rr[WordW-1] && rr[0]) rf_wd = '1;
              pc_d = npc;
            end
            OP_EQL: begin rf_we = 1'b1; rf_wd = {31'd0, a_s == b_s}; pc_d = npc; end
            OP_NEQ: begin rf_we = 1'b1; rf_wd = {31'd0, a_s != b_s}; pc_d = npc; end
            OP_LSS: begin rf_we = 1'b1; rf_wd = {31'd0, a_s < b_s}; pc_d = npc; end
            OP_LEQ: begin rf_we = 1'b1; rf_wd = {31'd0, a_s <= b_s}; pc_d = npc; end
            OP_GTR: begin rf_we = 1'b1; rf_wd = {31'd0, a_s > b_s}; pc_d = npc; end
            OP_GEQ: begin rf_we = 1'b1; rf_wd = {31'd0, a_s >= b_s}; pc_d = npc; end
            default: pc_d = npc;
          endcase
        end
      end
      S_WALK_RD: begin
        if (cnt_q == 3'd0) state_d = S_ACCESS;
        else if (!st_ok(base_q + 1)) begin status_d = ST_STACK; state_d = S_DONE; end
        else begin mem_ra = SW'(base_q + 1); state_d = S_WALK_WT; end
      end
      S_WALK_WT: begin
        base_d = wd_s; cnt_d = cnt_q - 3'd1; state_d = S_WALK_RD;
      end
      S_ACCESS: begin
        state_d = S_DONE;
        if (op_q == OP_CAL) begin
          if (!cd_ok(m_s)) status_d = ST_CODE;
          else begin cnt_d = 3'd0; state_d = S_CAL_WR; end
        end else if (!st_ok(addr_s)) status_d = ST_STACK;
        else if (op_q == OP_LOD) begin mem_ra = SW'(addr_s); state_d = S_LOD_WT; end
        else begin
          mem_we = 1'b1; mem_wa = SW'(addr_s); mem_wd = rr; pc_d = npc;
        end
      end
      S_LOD_WT: begin
        rf_we = 1'b1; rf_wd = rd_data_q; pc_d = npc; state_d = S_DONE;
      end
      S_CAL_WR: begin
        mem_we = 1'b1;
        mem_wa = sp_q + SW'(cnt_q) + SW'(1);
        case (cnt_q)
          3'd0:    mem_wd = '0;
          3'd1:    mem_wd = WordW'(base_q);
          3'd2:    mem_wd = WordW'(bp_q);
          default: mem_wd = WordW'(npc);
        endcase
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          bp_d = sp_q + SW'(1); pc_d = CW'(m_q); state_d = S_DONE;
        end
      end
      S_RTN_RD: begin
        aux_d = rd_data_q; mem_ra = bp_q + SW'(3); state_d = S_RTN_WT;
      end
      S_RTN_WT: begin
        state_d = S_DONE;
        if (!st_ok((WordW+2)'($signed(aux_q)))) status_d = ST_STACK;
        else if (!cd_ok(wd_s)) status_d = ST_CODE;
        else begin
          sp_d = bp_q - SW'(1); bp_d = SW'(aux_q); pc_d = CW'(rd_data_q);
        end
      end
      S_DIV_WT: begin
        if (drsp.done) begin
          rf_we = 1'b1; rf_wd = (op_q == OP_MOD) ? drsp.remainder : drsp.quotient;
          pc_d = npc; state_d = S_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      pc_q     <= '0;
      bp_q     <= SW'(1);
      sp_q     <= '0;
      halt_q   <= 1'b0;
      status_q <= ST_OK;
      cnt_q    <= '0;
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_q + SW'(1);
      pc_q     <= pc_d;
      bp_q     <= bp_d;
      sp_q     <= sp_d;
      halt_q   <= halt_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      if (rf_we) rf_q[r_q] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    aux_q  <= aux_d;
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= operation_i;
      r_q  <= dest_reg_i;
      l_q  <= level_or_src_i;
      m_q  <= operand_m_i;
      iv_q <= in_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    rd_data_q <= stack_mem[mem_ra];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign next_pc_o   = pc_q;
  assign base_ptr_o  = bp_q;
  assign stack_ptr_o = sp_q;
  assign reg_value_o = rr;
  assign halted_o    = halt_q;
  assign status_o    = status_q;

  a_fault_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && halt_q) |=> (pc_q == $past(pc_q)))
    else $error("pc moved after halt");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("ready while result pending");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pm0_pkg::*;

  localparam int StackDepth = 2048;
  localparam int CodeDepth = 512;
  localparam int IdleLimit = 8000;

  typedef struct packed {
    logic [8:0]  pc;
    logic [10:0] bp;
    logic [10:0] sp;
    logic [31:0] rv;
    logic        halted;
    status_e     st;
  } step_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [4:0] operation_i = '0;
  logic [2:0] dest_reg_i = '0;
  logic [2:0] level_or_src_i = '0;
  logic signed [31:0] operand_m_i = '0;
  logic signed [31:0] in_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [8:0] next_pc_o;
  logic [10:0] base_ptr_o;
  logic [10:0] stack_ptr_o;
  logic signed [31:0] reg_value_o;
  logic halted_o;
  logic [2:0] status_o;

  pm0_stack_machine_core dut (.*);

  logic [31:0] regs [8];
  logic [31:0] mem [StackDepth];
  longint pc_q, bp_q, sp_q;
  bit halt_q;
  step_result_t pending_steps[$];
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic bit in_stack(longint a);
    return a >= 0 && a < StackDepth;
  endfunction

  function automatic bit in_code(longint a);
    return a >= 0 && a < CodeDepth;
  endfunction

  function automatic bit follow_links(int lev, output longint b);
    longint cur;
    cur = bp_q;
    b = 0;
    for (int i = 0; i < lev; i++) begin
      if (!in_stack(cur + 1)) return 0;
      cur = sx(mem[cur + 1]);
    end
    b = cur;
    return 1;
  endfunction

  function automatic step_result_t execute_step(logic [4:0] op, logic [2:0] r, logic [2:0] l,
                                                logic [31:0] m_raw, logic [31:0] iv);
    step_result_t res;
    status_e st;
    longint m, a, bv, b, addr, nb, rp, s;
    longint npc;
    logic [2:0] mr;
    st = ST_OK;
    m = sx(m_raw);
    mr = m_raw[2:0];
    npc = (pc_q + 1) % CodeDepth;
    a = sx(regs[l]);
    bv = sx(regs[mr]);
    if (halt_q) begin
      st = ST_HALTED;
    end else begin
      case (op_e'(op))
        OP_LIT: regs[r] = m_raw;
        OP_RTN: begin
          if (bp_q < 1 || !in_stack(bp_q + 3)) st = ST_STACK;
          else begin
            nb = sx(mem[bp_q + 2]);
            rp = sx(mem[bp_q + 3]);
            if (!in_stack(nb)) st = ST_STACK;
            else if (!in_code(rp)) st = ST_CODE;
            else begin
              sp_q = bp_q - 1;
              bp_q = nb;
              npc = rp;
            end
          end
        end
        OP_LOD, OP_STO: begin
          if (!follow_links(l, b)) st = ST_STACK;
          else begin
            addr = b + m;
            if (!in_stack(addr)) st = ST_STACK;
            else if (op_e'(op) == OP_LOD) regs[r] = mem[addr];
            else mem[addr] = regs[r];
          end
        end
        OP_CAL: begin
          s = sp_q;
          if (!in_stack(s + 4) || !follow_links(l, b)) st = ST_STACK;
          else if (!in_code(m)) st = ST_CODE;
          else begin
            mem[s + 1] = '0;
            mem[s + 2] = b[31:0];
            mem[s + 3] = bp_q[31:0];
            mem[s + 4] = npc[31:0];
            bp_q = s + 1;
            npc = m;
          end
        end
        OP_INC: begin
          addr = sp_q + m;
          if (!in_stack(addr)) st = ST_STACK;
          else sp_q = addr;
        end
        OP_JMP: begin
          if (!in_code(m)) st = ST_CODE;
          else npc = m;
        end
        OP_JPC: begin
          if (regs[r] == '0) begin
            if (!in_code(m)) st = ST_CODE;
            else npc = m;
          end
        end
        OP_SIO: begin
          if (m_raw == SioRead) regs[r] = iv;
          else if (m_raw != SioWrite) begin
            halt_q = 1'b1;
            npc = 0;
            sp_q = 0;
          end
        end
        OP_NEG: regs[r] = '0 - regs[l];
        OP_ADD: regs[r] = regs[l] + regs[mr];
        OP_SUB: regs[r] = regs[l] - regs[mr];
        OP_MUL: regs[r] = regs[l] * regs[mr];
        OP_DIV, OP_MOD: begin
          if (bv == 0) st = ST_DIVZ;
          else if (op_e'(op) == OP_DIV) regs[r] = 32'(a / bv);
          else regs[r] = 32'(a % bv);
        end
        OP_ODD: regs[r] = 32'(sx(regs[r]) % 2);
        OP_EQL: regs[r] = 32'(a == bv);
        OP_NEQ: regs[r] = 32'(a != bv);
        OP_LSS: regs[r] = 32'(a < bv);
        OP_LEQ: regs[r] = 32'(a <= bv);
        OP_GTR: regs[r] = 32'(a > bv);
        OP_GEQ: regs[r] = 32'(a >= bv);
        default: ;
      endcase
      if (st == ST_OK) pc_q = npc;
    end
    res.pc = pc_q[8:0];
    res.bp = bp_q[10:0];
    res.sp = sp_q[10:0];
    res.rv = regs[r];
    res.halted = halt_q;
    res.st = st;
    return res;
  endfunction

  task automatic send_instr(op_e op, int r, int l, logic [31:0] m, logic [31:0] iv = $urandom);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i = op;
    dest_reg_i = r[2:0];
    level_or_src_i = l[2:0];
    operand_m_i = m;
    in_value_i = iv;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_steps.push_back(execute_step(op, r[2:0], l[2:0], m, iv));
    @(negedge clk_i);
  endtask

  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    step_result_t exp_r;
    if (out_valid_o && !out_stall_i) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        exp_r = pending_steps.pop_front();
        if (next_pc_o !== exp_r.pc) begin
          $error("next_pc exp %0d got %0d", exp_r.pc, next_pc_o); errors++;
        end
        if (base_ptr_o !== exp_r.bp) begin
          $error("base_ptr exp %0d got %0d", exp_r.bp, base_ptr_o); errors++;
        end
        if (stack_ptr_o !== exp_r.sp) begin
          $error("stack_ptr exp %0d got %0d", exp_r.sp, stack_ptr_o); errors++;
        end
        if (reg_value_o !== exp_r.rv) begin
          $error("reg_value exp %0d got %0d", $signed(exp_r.rv), reg_value_o); errors++;
        end
        if (halted_o !== exp_r.halted) begin
          $error("halted exp %0d got %0d", exp_r.halted, halted_o); errors++;
        end
        if (status_o !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, status_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_arith();
    send_instr(OP_LIT, 0, 0, 32'h8000_0000);
    send_instr(OP_LIT, 1, 0, 32'hFFFF_FFFF);
    send_instr(OP_LIT, 2, 0, 32'h7FFF_FFFF);
    send_instr(OP_DIV, 3, 0, 1);
    send_instr(OP_MOD, 4, 0, 1);
    send_instr(OP_DIV, 5, 2, 6);
    send_instr(OP_ADD, 5, 2, 1);
    send_instr(OP_SUB, 6, 0, 2);
    send_instr(OP_MUL, 7, 2, 32'hFFFF_FFF9);
    send_instr(OP_NEG, 3, 0, 0);
    send_instr(OP_ODD, 1, 0, 0);
    send_instr(OP_LSS, 4, 0, 2);
    send_instr(OP_EQL, 4, 0, 0);
    send_instr(OP_NEQ, 4, 0, 2);
    send_instr(OP_LEQ, 4, 2, 0);
    send_instr(OP_GTR, 4, 2, 0);
    send_instr(OP_GEQ, 4, 0, 2);
  endtask

  task automatic test_stack_and_flow();
    send_instr(OP_INC, 0, 0, 6);
    send_instr(OP_STO, 2, 0, 3);
    send_instr(OP_CAL, 0, 0, 200);
    send_instr(OP_INC, 0, 0, 4);
    send_instr(OP_LOD, 6, 1, 3);
    send_instr(OP_STO, 6, 7, 0);
    send_instr(OP_LOD, 6, 0, 32'h7FFF_FFFF);
    send_instr(OP_INC, 0, 0, 32'h8000_0000);
    send_instr(OP_CAL, 0, 0, 512);
    send_instr(OP_RTN, 0, 0, 0);
    send_instr(OP_JMP, 0, 0, 511);
    send_instr(op_e'(5'd0), 0, 0, 0);
    send_instr(OP_JMP, 0, 0, 32'hFFFF_FFFF);
    send_instr(OP_JPC, 3, 0, 100);
    send_instr(OP_JPC, 4, 0, 600);
    send_instr(OP_JPC, 6, 0, 600);
    send_instr(op_e'(5'd23), 1, 1, 0);
    send_instr(op_e'(5'd31), 7, 7, 32'hFFFF_FFFF);
    send_instr(OP_SIO, 5, 0, SioRead, 32'h8000_0001);
    send_instr(OP_SIO, 5, 0, SioWrite);
  endtask

  task automatic test_random(int count);
    int pick, r, l;
    logic [31:0] m;
    op_e op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 7);
      l = $urandom_range(0, 7);
      m = $urandom_range(0, 7);
      if (pick < 12) begin
        op = OP_LIT;
        m = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20) - 10;
      end else if (pick < 40) begin
        op = op_e'($urandom_range(OP_NEG, OP_GEQ));
      end else if (pick < 52) begin
        op = ($urandom_range(0, 1) == 0) ? OP_LOD : OP_STO;
        l = $urandom_range(0, 2);
        m = $urandom_range(0, 8);
      end else if (pick < 60) begin
        op = OP_INC;
        m = (sp_q > 1900) ? -$urandom_range(0, 200) : $urandom_range(0, 10);
      end else if (pick < 67) begin
        op = (sp_q < 2000) ? OP_CAL : OP_RTN;
        l = $urandom_range(0, 2);
        m = $urandom_range(0, CodeDepth - 1);
      end else if (pick < 74) begin
        op = OP_RTN;
      end else if (pick < 84) begin
        op = ($urandom_range(0, 1) == 0) ? OP_JMP : OP_JPC;
        m = $urandom_range(0, CodeDepth - 1);
      end else if (pick < 90) begin
        op = OP_SIO;
        m = ($urandom_range(0, 1) == 0) ? SioRead : SioWrite;
      end else begin
        op = op_e'($urandom_range(0, 31));
        m = $urandom;
        if (op == OP_SIO) m = SioRead;
      end
      send_instr(op, r, l, m);
    end
  endtask

  task automatic test_halt();
    send_instr(OP_SIO, 2, 0, 3);
    send_instr(OP_LIT, 2, 0, 5);
    send_instr(OP_SIO, 0, 0, SioRead);
  endtask

  initial begin
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    pc_q = 0;
    bp_q = 1;
    sp_q = 0;
    halt_q = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_arith();
    test_stack_and_flow();
    test_random(950);
    test_halt();
    in_valid_i = 1'b0;
    wait (pending_steps.size() == 0);
    repeat (60) @(negedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
